@@ src/urtb_pkg.sv @@
// ----------------------------------------------------------------------------
// urtb_pkg
// Shared constants, event codes and the command word for the UART ring buffers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package urtb_pkg;

  // Word field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned AVAIL_W = 6;

  localparam logic [AVAIL_W-1:0] AVAIL_MAX = '1;

  // Default ring depths and command queue depth
  localparam int unsigned RX_DEPTH_DEF    = 64;
  localparam int unsigned TX_DEPTH_DEF    = 64;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Widest ring pointer over the supported depth range (up to 1024)
  localparam int unsigned PTR_W_MAX = 10;

  // Event codes
  localparam logic [FUNC_W-1:0] FUNC_RX_BYTE   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_HOST_RD   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_HOST_WR   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TX_READY  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RX_CLEAR  = 3'd4;

  // Storage operation carried out by the back end
  typedef enum logic [2:0] {
    OP_NONE,
    OP_RX_WR,
    OP_RX_RD,
    OP_TX_WR,
    OP_TX_RD
  } op_e;

  // One classified event: storage access plus the status already known
  typedef struct packed {
    op_e                  op;
    logic [PTR_W_MAX-1:0] addr;
    logic [BYTE_W-1:0]    data;
    logic                 read_valid;
    logic                 tx_valid;
    logic                 write_accepted;
    logic                 rx_dropped;
    logic [AVAIL_W-1:0]   rx_available;
    logic                 tx_busy;
  } cmd_t;

endpackage

@@ src/urtb_in_if.sv @@
// ----------------------------------------------------------------------------
// urtb_in_if
// Event channel: valid/ready handshake with the event payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface urtb_in_if;
  logic                        valid;
  logic                        ready;
  logic [urtb_pkg::FUNC_W-1:0] func;
  logic [urtb_pkg::BYTE_W-1:0] data;
  logic                        parity_error;

  modport source (output valid, func, data, parity_error, input ready);
  modport sink   (input valid, func, data, parity_error, output ready);
endinterface

@@ src/urtb_out_if.sv @@
// ----------------------------------------------------------------------------
// urtb_out_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface urtb_out_if;
  logic                         valid;
  logic                         ready;
  logic [urtb_pkg::BYTE_W-1:0]  read_data;
  logic                         read_valid;
  logic [urtb_pkg::BYTE_W-1:0]  tx_data;
  logic                         tx_valid;
  logic                         write_accepted;
  logic                         rx_dropped;
  logic [urtb_pkg::AVAIL_W-1:0] rx_available;
  logic                         tx_busy;

  modport source (output valid, read_data, read_valid, tx_data, tx_valid,
                  write_accepted, rx_dropped, rx_available, tx_busy,
                  input ready);
  modport sink   (input valid, read_data, read_valid, tx_data, tx_valid,
                  write_accepted, rx_dropped, rx_available, tx_busy,
                  output ready);
endinterface

@@ src/uart_rx_tx_ring_buffers.sv @@
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// UART receive ring and transmit queue with one status word per event.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one event word per handshake (func, data, parity_error). Events are
//           rx byte arrived, host read, host write, transmitter ready, rx clear.
//   out_o : exactly one result word per event, in event order: popped byte,
//           byte handed to the transmitter, write accept, rx drop flag, rx fill
//           level (saturating at 63) and transmitter busy.
//   Results pass through the command queue, middle stage and result register.
//   Throughput: one event per cycle sustained while out_o.ready holds; each
//   event makes at most one access to one ring RAM, whose single write and
//   single registered read port set that figure.
//   The front end updates pointers at acceptance; the back end performs the
//   RAM accesses in order behind a short command queue, so a byte is never
//   overwritten before an earlier queued read has fetched it.
//   Reset: pointers clear, transmitter holding register marked free, queue and
//   result stages empty. Ring contents are not cleared and need no sweep.
//   Receiver stall: the result word holds, the middle stage and the command
//   queue fill, and then in_i.ready drops until out_o.ready returns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers #(
  parameter int unsigned RX_DEPTH    = urtb_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH    = urtb_pkg::TX_DEPTH_DEF,
  parameter int unsigned QUEUE_DEPTH = urtb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  urtb_in_if.sink    in_i,
  urtb_out_if.source out_o
);
  import urtb_pkg::*;

  // front -> queue
  logic f_valid, f_ready;
  cmd_t f_cmd;
  // queue -> back
  logic b_valid, b_ready;
  cmd_t b_cmd;

  urtb_front #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  urtb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_cmd_i   (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_cmd_o    (b_cmd)
  );

  urtb_back #(.RX_DEPTH(RX_DEPTH), .TX_DEPTH(TX_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .cmd_i       (b_cmd),
    .out_o       (out_o)
  );

  // A single event never both pops a byte and feeds the transmitter
  a_one_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.read_valid && out_o.tx_valid))
    else $error("read and transmit in one result word");

  // Empty read returns zero data
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.read_valid |-> out_o.read_data == '0)
    else $error("read data not zero without a popped byte");

  // A drop belongs to an rx byte event only
  a_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.rx_dropped |-> !out_o.read_valid && !out_o.write_accepted)
    else $error("rx drop flagged together with another event result");

  // Handing a byte to the transmitter always leaves it busy
  a_tx_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.tx_valid |-> out_o.tx_busy)
    else $error("transmitter idle after a byte was handed over");

  // The front end only refuses events while the command queue is full
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> b_valid && !f_ready)
    else $error("event refused with room in the command queue");

endmodule

@@ src/urtb_ram.sv @@
// ----------------------------------------------------------------------------
// urtb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urtb_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 64,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/urtb_front.sv @@
// ----------------------------------------------------------------------------
// urtb_front
// Event front end: owns the ring pointers, classifies each event and emits
// a command word with the resulting status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urtb_front #(
  parameter int unsigned RX_DEPTH = urtb_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = urtb_pkg::TX_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  urtb_in_if.sink         in_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output urtb_pkg::cmd_t  cmd_o
);
  import urtb_pkg::*;

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);
  localparam int unsigned CNT_W = (RX_AW + 1 > AVAIL_W) ? RX_AW + 1 : AVAIL_W;

  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  logic [RX_AW-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d;
  logic [TX_AW-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d;
  logic             hold_free_q, hold_free_d;

  logic [RX_AW-1:0] rx_wr_nxt, rx_rd_nxt;
  logic [TX_AW-1:0] tx_wr_nxt, tx_rd_nxt;
  logic             tx_empty;
  logic [CNT_W-1:0] rx_cnt;
  logic             accept;
  cmd_t             cmd;

  assign accept      = in_i.valid & cmd_ready_i;
  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;
  assign cmd_o       = cmd;

  assign rx_wr_nxt = (rx_wr_q == RX_LAST) ? '0 : rx_wr_q + 1'b1;
  assign rx_rd_nxt = (rx_rd_q == RX_LAST) ? '0 : rx_rd_q + 1'b1;
  assign tx_wr_nxt = (tx_wr_q == TX_LAST) ? '0 : tx_wr_q + 1'b1;
  assign tx_rd_nxt = (tx_rd_q == TX_LAST) ? '0 : tx_rd_q + 1'b1;
  assign tx_empty  = (tx_wr_q == tx_rd_q);

  always_comb begin
    rx_wr_d     = rx_wr_q;
    rx_rd_d     = rx_rd_q;
    tx_wr_d     = tx_wr_q;
    tx_rd_d     = tx_rd_q;
    hold_free_d = hold_free_q;

    cmd                = '0;
    cmd.op             = OP_NONE;
    cmd.data           = in_i.data;

    case (in_i.func)
      FUNC_RX_BYTE: begin
        if (in_i.parity_error || rx_wr_nxt == rx_rd_q) begin
          cmd.rx_dropped = 1'b1;
        end else begin
          cmd.op   = OP_RX_WR;
          cmd.addr = PTR_W_MAX'(rx_wr_q);
          rx_wr_d  = rx_wr_nxt;
        end
      end
      FUNC_HOST_RD: begin
        if (rx_wr_q != rx_rd_q) begin
          cmd.op         = OP_RX_RD;
          cmd.addr       = PTR_W_MAX'(rx_rd_q);
          cmd.read_valid = 1'b1;
          rx_rd_d        = rx_rd_nxt;
        end
      end
      FUNC_HOST_WR: begin
        if (tx_empty && hold_free_q) begin
          // straight into the transmitter holding register
          cmd.tx_valid       = 1'b1;
          cmd.write_accepted = 1'b1;
          hold_free_d        = 1'b0;
        end else if (tx_wr_nxt != tx_rd_q) begin
          cmd.op             = OP_TX_WR;
          cmd.addr           = PTR_W_MAX'(tx_wr_q);
          cmd.write_accepted = 1'b1;
          tx_wr_d            = tx_wr_nxt;
        end
      end
      FUNC_TX_READY: begin
        if (!tx_empty) begin
          cmd.op       = OP_TX_RD;
          cmd.addr     = PTR_W_MAX'(tx_rd_q);
          cmd.tx_valid = 1'b1;
          tx_rd_d      = tx_rd_nxt;
          hold_free_d  = 1'b0;
        end else begin
          hold_free_d  = 1'b1;
        end
      end
      FUNC_RX_CLEAR: begin
        rx_wr_d = rx_rd_q;
      end
      default: begin
      end
    endcase

    // status after the event
    if (rx_wr_d >= rx_rd_d) begin
      rx_cnt = CNT_W'(rx_wr_d) - CNT_W'(rx_rd_d);
    end else begin
      rx_cnt = CNT_W'(rx_wr_d) + CNT_W'(RX_DEPTH) - CNT_W'(rx_rd_d);
    end
    cmd.rx_available = (rx_cnt > CNT_W'(AVAIL_MAX)) ? AVAIL_MAX : rx_cnt[AVAIL_W-1:0];
    cmd.tx_busy      = (tx_wr_d != tx_rd_d) | ~hold_free_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr_q     <= '0;
      rx_rd_q     <= '0;
      tx_wr_q     <= '0;
      tx_rd_q     <= '0;
      hold_free_q <= 1'b1;
    end else if (accept) begin
      rx_wr_q     <= rx_wr_d;
      rx_rd_q     <= rx_rd_d;
      tx_wr_q     <= tx_wr_d;
      tx_rd_q     <= tx_rd_d;
      hold_free_q <= hold_free_d;
    end
  end

endmodule

@@ src/urtb_queue.sv @@
// ----------------------------------------------------------------------------
// urtb_queue
// Short command queue between front and back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urtb_queue #(
  parameter int unsigned DEPTH = urtb_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  urtb_pkg::cmd_t push_cmd_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output urtb_pkg::cmd_t pop_cmd_o
);
  import urtb_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  cmd_t          slot_q [DEPTH];
  logic [IW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          full, empty, push, pop;

  assign full  = (cnt_q == CW'(DEPTH));
  assign empty = (cnt_q == '0);
  assign push  = push_valid_i & ~full;
  assign pop   = pop_ready_i & ~empty;

  assign push_ready_o = ~full;
  assign pop_valid_o  = ~empty;
  assign pop_cmd_o    = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ src/urtb_back.sv @@
// ----------------------------------------------------------------------------
// urtb_back
// Back end: performs ring storage accesses in order and registers results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urtb_back #(
  parameter int unsigned RX_DEPTH = urtb_pkg::RX_DEPTH_DEF,
  parameter int unsigned TX_DEPTH = urtb_pkg::TX_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  urtb_pkg::cmd_t cmd_i,
  urtb_out_if.source     out_o
);
  import urtb_pkg::*;

  localparam int unsigned RX_AW = $clog2(RX_DEPTH);
  localparam int unsigned TX_AW = $clog2(TX_DEPTH);

  logic              s1_valid_q;
  cmd_t              s1_cmd_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] read_data_q, tx_data_q;
  logic              read_valid_q, tx_valid_q, accepted_q, dropped_q, tx_busy_q;
  logic [AVAIL_W-1:0] avail_q;

  logic              out_adv, s1_free, pop;
  logic [BYTE_W-1:0] rx_rdata, tx_rdata;

  assign out_adv     = ~out_valid_q | out_o.ready;
  assign s1_free     = ~s1_valid_q | out_adv;
  assign cmd_ready_o = s1_free;
  assign pop         = cmd_valid_i & s1_free;

  urtb_ram #(.WIDTH(BYTE_W), .DEPTH(RX_DEPTH)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (pop && cmd_i.op == OP_RX_WR),
    .waddr_i (cmd_i.addr[RX_AW-1:0]),
    .wdata_i (cmd_i.data),
    .re_i    (pop && cmd_i.op == OP_RX_RD),
    .raddr_i (cmd_i.addr[RX_AW-1:0]),
    .rdata_o (rx_rdata)
  );

  urtb_ram #(.WIDTH(BYTE_W), .DEPTH(TX_DEPTH)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (pop && cmd_i.op == OP_TX_WR),
    .waddr_i (cmd_i.addr[TX_AW-1:0]),
    .wdata_i (cmd_i.data),
    .re_i    (pop && cmd_i.op == OP_TX_RD),
    .raddr_i (cmd_i.addr[TX_AW-1:0]),
    .rdata_o (tx_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= cmd_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload: read data stays put while stage 1 waits, as no new read issues
  always_ff @(posedge clk_i) begin
    if (pop) begin
      s1_cmd_q <= cmd_i;
    end
    if (out_adv && s1_valid_q) begin
      read_valid_q <= s1_cmd_q.read_valid;
      read_data_q  <= s1_cmd_q.read_valid ? rx_rdata : '0;
      tx_valid_q   <= s1_cmd_q.tx_valid;
      if (s1_cmd_q.op == OP_TX_RD) begin
        tx_data_q <= tx_rdata;
      end else begin
        tx_data_q <= s1_cmd_q.tx_valid ? s1_cmd_q.data : '0;
      end
      accepted_q <= s1_cmd_q.write_accepted;
      dropped_q  <= s1_cmd_q.rx_dropped;
      avail_q    <= s1_cmd_q.rx_available;
      tx_busy_q  <= s1_cmd_q.tx_busy;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.read_data      = read_data_q;
  assign out_o.read_valid     = read_valid_q;
  assign out_o.tx_data        = tx_data_q;
  assign out_o.tx_valid       = tx_valid_q;
  assign out_o.write_accepted = accepted_q;
  assign out_o.rx_dropped     = dropped_q;
  assign out_o.rx_available   = avail_q;
  assign out_o.tx_busy        = tx_busy_q;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives event words into the UART ring buffers with random gaps and stalls,
// predicts each status word from a behavioural copy of both rings, and
// compares every result word field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import urtb_pkg::*;

  // Ring sizes follow the block's default parameters
  localparam int unsigned RX_RING = RX_DEPTH_DEF;
  localparam int unsigned TX_RING = TX_DEPTH_DEF;

  // Codes the block must treat as no-ops
  localparam logic [FUNC_W-1:0] FUNC_SPARE_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_7 = 3'd7;

  // Words sent per idling phase before moving to the next one
  localparam int unsigned PHASE_LEN = 50;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] data;
    logic              parity_error;
  } uart_evt_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  read_data;
    logic               read_valid;
    logic [BYTE_W-1:0]  tx_data;
    logic               tx_valid;
    logic               write_accepted;
    logic               rx_dropped;
    logic [AVAIL_W-1:0] rx_available;
    logic               tx_busy;
  } status_t;

  logic clk_i;
  logic rst_ni;

  urtb_in_if  in_if ();
  urtb_out_if out_if ();

  uart_rx_tx_ring_buffers uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #2 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Behavioural copy of the two rings. Pointers run modulo the ring size and
  // one slot is always left unused, so equal pointers mean empty.
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] rx_ring [RX_RING];
  logic [BYTE_W-1:0] tx_ring [TX_RING];
  int unsigned       rx_wr_ptr = 0;
  int unsigned       rx_rd_ptr = 0;
  int unsigned       tx_wr_ptr = 0;
  int unsigned       tx_rd_ptr = 0;
  logic              holding_free = 1'b1;

  uart_evt_t   pending_events [$];   // words still to be driven
  status_t     status_due [$];       // predicted status, oldest first
  uart_evt_t   in_flight;            // word currently offered on in_if
  int unsigned words_sent = 0;       // accepted words, also sets the phase
  int unsigned mismatches = 0;

  // Apply one event to the copy of the rings and return the status word the
  // block should report for it.
  function automatic status_t next_status(uart_evt_t ev);
    status_t     s;
    int unsigned fill;
    s = '0;
    case (ev.func)
      FUNC_RX_BYTE: begin
        // parity errors and a full ring both drop the byte
        if (ev.parity_error || (rx_wr_ptr + 1) % RX_RING == rx_rd_ptr) begin
          s.rx_dropped = 1'b1;
        end else begin
          rx_ring[rx_wr_ptr] = ev.data;
          rx_wr_ptr = (rx_wr_ptr + 1) % RX_RING;
        end
      end
      FUNC_HOST_RD: begin
        // an empty ring answers with read_valid low and a zero byte
        if (rx_wr_ptr != rx_rd_ptr) begin
          s.read_data  = rx_ring[rx_rd_ptr];
          s.read_valid = 1'b1;
          rx_rd_ptr = (rx_rd_ptr + 1) % RX_RING;
        end
      end
      FUNC_HOST_WR: begin
        if (tx_wr_ptr == tx_rd_ptr && holding_free) begin
          // straight through to the transmitter
          s.tx_data        = ev.data;
          s.tx_valid       = 1'b1;
          s.write_accepted = 1'b1;
          holding_free     = 1'b0;
        end else if ((tx_wr_ptr + 1) % TX_RING != tx_rd_ptr) begin
          tx_ring[tx_wr_ptr] = ev.data;
          tx_wr_ptr = (tx_wr_ptr + 1) % TX_RING;
          s.write_accepted = 1'b1;
        end
        // queue full: refused, nothing changes
      end
      FUNC_TX_READY: begin
        if (tx_wr_ptr != tx_rd_ptr) begin
          s.tx_data    = tx_ring[tx_rd_ptr];
          s.tx_valid   = 1'b1;
          tx_rd_ptr    = (tx_rd_ptr + 1) % TX_RING;
          holding_free = 1'b0;
        end else begin
          holding_free = 1'b1;
        end
      end
      FUNC_RX_CLEAR: rx_wr_ptr = rx_rd_ptr;
      default: ;
    endcase
    fill = (RX_RING + rx_wr_ptr - rx_rd_ptr) % RX_RING;
    s.rx_available = (fill > AVAIL_MAX) ? AVAIL_MAX : fill[AVAIL_W-1:0];
    s.tx_busy      = (tx_wr_ptr != tx_rd_ptr) || !holding_free;
    return s;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Idling phases: none, sender gaps, receiver stalls, then both lighter
  function automatic int unsigned send_gap_pct(int unsigned n);
    case ((n / PHASE_LEN) % 4)
      1:       return 53;
      3:       return 22;
      default: return 0;
    endcase
  endfunction

  function automatic int unsigned stall_pct(int unsigned n);
    case ((n / PHASE_LEN) % 4)
      2:       return 53;
      3:       return 22;
      default: return 0;
    endcase
  endfunction

  task automatic add_evt(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] data, logic perr);
    uart_evt_t ev;
    ev.func         = func;
    ev.data         = data;
    ev.parity_error = perr;
    pending_events.push_back(ev);
  endtask

  // --------------------------------------------------------------------------
  // Driver: offers the next pending word, holds it until accepted, and
  // predicts its status at the edge where the handshake completes.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid        <= 1'b0;
      in_if.func         <= FUNC_RX_BYTE;
      in_if.data         <= '0;
      in_if.parity_error <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        status_due.push_back(next_status(in_flight));
        words_sent <= words_sent + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= send_gap_pct(words_sent)) begin
          in_flight = pending_events.pop_front();
          in_if.valid        <= 1'b1;
          in_if.func         <= in_flight.func;
          in_if.data         <= in_flight.data;
          in_if.parity_error <= in_flight.parity_error;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stalls the result channel at random and checks every word taken
  // against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    status_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (status_due.size() == 0) begin
          $display("%0t: result word with none expected: rx_available %0d tx_busy %0d",
                   $time, out_if.rx_available, out_if.tx_busy);
          mismatches++;
        end else begin
          want = status_due.pop_front();
          check_field("read_data",      want.read_data,      out_if.read_data);
          check_field("read_valid",     want.read_valid,     out_if.read_valid);
          check_field("tx_data",        want.tx_data,        out_if.tx_data);
          check_field("tx_valid",       want.tx_valid,       out_if.tx_valid);
          check_field("write_accepted", want.write_accepted, out_if.write_accepted);
          check_field("rx_dropped",     want.rx_dropped,     out_if.rx_dropped);
          check_field("rx_available",   want.rx_available,   out_if.rx_available);
          check_field("tx_busy",        want.tx_busy,        out_if.tx_busy);
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct(words_sent));
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // --------------------------------------------------------------------------
  initial begin
    logic [FUNC_W-1:0] any_func [8];
    int unsigned       len;
    int unsigned       kind;
    logic [FUNC_W-1:0] f;

    clk_i  = 1'b0;
    rst_ni = 1'b0;

    any_func = '{FUNC_RX_BYTE, FUNC_HOST_RD, FUNC_HOST_WR, FUNC_TX_READY,
                 FUNC_RX_CLEAR, FUNC_SPARE_5, FUNC_SPARE_6, FUNC_SPARE_7};

    // Directed opening: empty read, byte extremes, parity drop, bypass and
    // queued writes, dequeue, ready on an empty queue, clear and spare codes.
    add_evt(FUNC_HOST_RD,  8'h00, 1'b0);
    add_evt(FUNC_RX_BYTE,  8'h00, 1'b0);
    add_evt(FUNC_RX_BYTE,  8'hFF, 1'b0);
    add_evt(FUNC_RX_BYTE,  8'hA5, 1'b1);
    add_evt(FUNC_HOST_RD,  8'h00, 1'b0);
    add_evt(FUNC_HOST_WR,  8'hFF, 1'b0);
    add_evt(FUNC_HOST_WR,  8'h00, 1'b0);
    add_evt(FUNC_HOST_WR,  8'h5A, 1'b0);
    add_evt(FUNC_TX_READY, 8'h00, 1'b0);
    add_evt(FUNC_TX_READY, 8'h00, 1'b0);
    add_evt(FUNC_TX_READY, 8'h00, 1'b0);
    add_evt(FUNC_TX_READY, 8'hFF, 1'b1);
    add_evt(FUNC_HOST_WR,  8'h3C, 1'b0);
    add_evt(FUNC_RX_CLEAR, 8'hFF, 1'b1);
    add_evt(FUNC_HOST_RD,  8'hFF, 1'b0);
    add_evt(FUNC_SPARE_5,  8'hFF, 1'b1);
    add_evt(FUNC_SPARE_6,  8'h00, 1'b0);
    add_evt(FUNC_SPARE_7,  8'hFF, 1'b1);
    add_evt(FUNC_RX_BYTE,  8'h12, 1'b0);
    add_evt(FUNC_RX_CLEAR, 8'h00, 1'b0);
    add_evt(FUNC_HOST_RD,  8'h00, 1'b0);
    add_evt(FUNC_TX_READY, 8'h00, 1'b0);

    // Random part in bursts: long fills reach the full-ring and full-queue
    // cases, drains empty them again, mixed runs interleave both sides and
    // a little noise covers the spare codes.
    while (pending_events.size() < 450) begin
      kind = $urandom_range(9);
      case (kind)
        0, 1, 2, 3: len = $urandom_range(80, 40);
        4:          len = 1;
        default:    len = $urandom_range(20, 1);
      endcase
      for (int unsigned i = 0; i < len && pending_events.size() < 450; i++) begin
        case (kind)
          0:       f = FUNC_RX_BYTE;
          1:       f = FUNC_HOST_RD;
          2:       f = FUNC_HOST_WR;
          3:       f = FUNC_TX_READY;
          4:       f = FUNC_RX_CLEAR;
          9:       f = any_func[$urandom_range(7)];
          default: f = any_func[$urandom_range(4)];
        endcase
        add_evt(f, 8'($urandom_range(255)),
                (kind == 9) ? 1'($urandom_range(1)) : ($urandom_range(15) == 0));
      end
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Everything offered and taken, then every prediction answered
    while (pending_events.size() != 0 || in_if.valid) @(negedge clk_i);
    while (status_due.size() != 0) @(negedge clk_i);
    // a few spare cycles to catch any stray result word
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

endmodule
